FILE: design/rhsm_pkg.sv
// ----------------------------------------------------------------------------
// rhsm_pkg
// Shared types and constants of the two-pattern rolling-hash matcher.
// ----------------------------------------------------------------------------
package rhsm_pkg;

  localparam logic [31:0] HASH_BASE = 32'd53;
  localparam logic [31:0] CHAR_BIAS = 32'd97;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_A = 3'd0,
    REG_LEN_A  = 3'd1,
    REG_POW_A  = 3'd2,
    REG_HASH_B = 3'd3,
    REG_LEN_B  = 3'd4,
    REG_POW_B  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] hash_a;
    logic [7:0]  len_a;
    logic [31:0] pow_a;
    logic [31:0] hash_b;
    logic [7:0]  len_b;
    logic [31:0] pow_b;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    hash_a: 32'd0, len_a: 8'd1, pow_a: 32'd53,
    hash_b: 32'd0, len_b: 8'd1, pow_b: 32'd53
  };

  // Front stage -> match stage. Index 0 of the flag pairs is pattern A.
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [31:0] prefix;
    logic [1:0]  ok;     // window length legal and enough text taken
    logic [1:0]  zero;   // window starts at text start: older prefix is zero
  } s1_t;

  typedef enum logic [2:0] {
    PH_SEEK_A = 3'b001,
    PH_SEEK_B = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

endpackage

FILE: design/rhsm_if.sv
// ----------------------------------------------------------------------------
// rhsm_if
// Valid/ready channels of the matcher: text bytes in, verdicts out.
// ----------------------------------------------------------------------------
interface rhsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface rhsm_out_if;
  logic valid;
  logic ready;
  logic found;
  logic a_found;

  modport source (output valid, output found, output a_found, input ready);
  modport sink   (input valid, input found, input a_found, output ready);
endinterface

FILE: design/rhsm_ram.sv
// ----------------------------------------------------------------------------
// rhsm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module rhsm_ram #(
  parameter int Width = 32,
  parameter int Depth = 129,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

FILE: design/rhsm_front.sv
// ----------------------------------------------------------------------------
// rhsm_front
// Prefix hash update, ring pointer, history write and window-start reads.
// ----------------------------------------------------------------------------
module rhsm_front import rhsm_pkg::*; #(
  parameter int MAX_PAT = 128,
  localparam int RingDepth = MAX_PAT + 1,
  localparam int AddrW = $clog2(RingDepth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rhsm_in_if.sink          text_i,
  input  cfg_t             cfg_i,
  input  logic             advance_i,
  output s1_t              s1_o,
  output logic             ram_we_o,
  output logic [AddrW-1:0] ram_waddr_o,
  output logic [31:0]      ram_wdata_o,
  output logic             ram_re_o,
  output logic [AddrW-1:0] ram_raddr_a_o,
  output logic [AddrW-1:0] ram_raddr_b_o
);

  localparam int IdxW  = $clog2(2 * RingDepth);
  localparam int FillW = $clog2(MAX_PAT + 1);
  localparam int CmpW  = (FillW > 8) ? FillW : 8;

  logic [31:0]      prefix_q, prefix_d, prefix_new, term;
  logic [AddrW-1:0] ptr_q, ptr_d, ptr_new;
  logic [FillW-1:0] filled_q, filled_d, filled_new;
  logic             wrapped_q, wrapped_d, wrapped_new;
  logic             in_acc;
  s1_t              s1_q, s1_d;

  logic [7:0]       len     [2];
  logic [7:0]       len_eff [2];
  logic             len_ok  [2];
  logic [IdxW-1:0]  idx_sum [2];
  logic [AddrW-1:0] idx     [2];

  assign text_i.ready = advance_i;
  assign in_acc       = text_i.valid & advance_i;
  assign len[0]       = cfg_i.len_a;
  assign len[1]       = cfg_i.len_b;

  always_comb begin
    term        = {24'd0, text_i.char_code} - CHAR_BIAS;
    prefix_new  = 32'(prefix_q * HASH_BASE) + term;
    ptr_new     = (ptr_q == AddrW'(RingDepth - 1)) ? '0 : ptr_q + 1'b1;
    filled_new  = (filled_q == FillW'(MAX_PAT)) ? filled_q : filled_q + 1'b1;
    // slot zero stands for the empty-text prefix until the ring wraps onto it
    wrapped_new = wrapped_q | (ptr_new == '0);

    s1_d        = s1_q;
    s1_d.valid  = in_acc;
    s1_d.last   = text_i.last;
    s1_d.prefix = prefix_new;
    for (int i = 0; i < 2; i++) begin
      len_ok[i]    = (len[i] != 8'd0) && (CmpW'(len[i]) <= CmpW'(MAX_PAT));
      len_eff[i]   = len_ok[i] ? len[i] : 8'd1;
      idx_sum[i]   = IdxW'(ptr_new) + IdxW'(RingDepth) - IdxW'(len_eff[i]);
      idx[i]       = (idx_sum[i] >= IdxW'(RingDepth)) ?
                     AddrW'(idx_sum[i] - IdxW'(RingDepth)) : AddrW'(idx_sum[i]);
      s1_d.ok[i]   = len_ok[i] && (CmpW'(filled_new) >= CmpW'(len[i]));
      s1_d.zero[i] = (idx[i] == '0) && !wrapped_new;
    end

    prefix_d  = prefix_q;
    ptr_d     = ptr_q;
    filled_d  = filled_q;
    wrapped_d = wrapped_q;
    if (in_acc) begin
      if (text_i.last) begin
        prefix_d  = '0;
        ptr_d     = '0;
        filled_d  = '0;
        wrapped_d = 1'b0;
      end else begin
        prefix_d  = prefix_new;
        ptr_d     = ptr_new;
        filled_d  = filled_new;
        wrapped_d = wrapped_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q  <= '0;
      ptr_q     <= '0;
      filled_q  <= '0;
      wrapped_q <= 1'b0;
      s1_q      <= '0;
    end else begin
      prefix_q  <= prefix_d;
      ptr_q     <= ptr_d;
      filled_q  <= filled_d;
      wrapped_q <= wrapped_d;
      if (advance_i) begin
        s1_q <= s1_d;
      end
    end
  end

  assign s1_o          = s1_q;
  assign ram_we_o      = in_acc;
  assign ram_waddr_o   = ptr_new;
  assign ram_wdata_o   = prefix_new;
  assign ram_re_o      = advance_i;
  assign ram_raddr_a_o = idx[0];
  assign ram_raddr_b_o = idx[1];

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && text_i.last) |=> (prefix_q == '0 && ptr_q == '0 && !wrapped_q))
    else $error("text state not cleared after last byte");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= AddrW'(RingDepth - 1))
    else $error("ring pointer out of range");

endmodule

FILE: design/rhsm_match.sv
// ----------------------------------------------------------------------------
// rhsm_match
// Window hash compare for both patterns, search phase and verdict register.
// ----------------------------------------------------------------------------
module rhsm_match import rhsm_pkg::*; #(
  parameter int MAX_PAT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  s1_t         s1_i,
  input  logic [31:0] rdata_a_i,
  input  logic [31:0] rdata_b_i,
  rhsm_out_if.source  verdict_o,
  output logic        advance_o
);

  localparam int CntW = $clog2(MAX_PAT + 1);
  localparam int CmpW = (CntW > 8) ? CntW : 8;

  logic [31:0]     hist    [2];
  logic [31:0]     prod_d  [2];
  logic [31:0]     prod_q  [2];
  logic [31:0]     win     [2];
  logic [31:0]     target  [2];
  logic [1:0]      match;
  logic            s2_valid_q, s2_last_q;
  logic [31:0]     s2_prefix_q;
  logic [1:0]      s2_ok_q;
  phase_e          phase_q, phase_d, phase_upd;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_upd, cnt_inc;
  logic            eval;
  logic            out_valid_q, out_valid_d, found_q, found_d, a_found_q, a_found_d;

  assign hist[0]   = s1_i.zero[0] ? '0 : rdata_a_i;
  assign hist[1]   = s1_i.zero[1] ? '0 : rdata_b_i;
  assign prod_d[0] = cfg_i.pow_a * hist[0];
  assign prod_d[1] = cfg_i.pow_b * hist[1];
  assign target[0] = cfg_i.hash_a;
  assign target[1] = cfg_i.hash_b;

  // stall only when a verdict must go out and the output register is held
  assign advance_o = !(s2_valid_q && s2_last_q && out_valid_q && !verdict_o.ready);
  assign eval      = s2_valid_q && advance_o;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      win[i]   = s2_prefix_q - prod_q[i];
      match[i] = s2_ok_q[i] && (win[i] == target[i]);
    end
    cnt_inc   = (cnt_q == CntW'(MAX_PAT)) ? cnt_q : cnt_q + 1'b1;
    phase_upd = phase_q;
    cnt_upd   = cnt_q;
    unique case (phase_q)
      PH_SEEK_A: begin
        if (match[0]) begin
          phase_upd = PH_SEEK_B;
          cnt_upd   = '0;
        end
      end
      PH_SEEK_B: begin
        cnt_upd = cnt_inc;
        // B must start at or after the end of the A window
        if (match[1] && (CmpW'(cnt_inc) >= CmpW'(cfg_i.len_b))) begin
          phase_upd = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: phase_upd = PH_SEEK_A;
    endcase

    found_d     = found_q;
    a_found_d   = a_found_q;
    out_valid_d = out_valid_q & ~verdict_o.ready;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    if (eval) begin
      if (s2_last_q) begin
        out_valid_d = 1'b1;
        found_d     = (phase_upd == PH_DONE);
        a_found_d   = (phase_upd != PH_SEEK_A);
        phase_d     = PH_SEEK_A;
        cnt_d       = '0;
      end else begin
        phase_d = phase_upd;
        cnt_d   = cnt_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      phase_q     <= PH_SEEK_A;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      a_found_q   <= 1'b0;
    end else begin
      if (advance_o) begin
        s2_valid_q <= s1_i.valid;
        s2_last_q  <= s1_i.last;
      end
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      a_found_q   <= a_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      s2_prefix_q <= s1_i.prefix;
      s2_ok_q     <= s1_i.ok;
      prod_q[0]   <= prod_d[0];
      prod_q[1]   <= prod_d[1];
    end
  end

  assign verdict_o.valid   = out_valid_q;
  assign verdict_o.found   = found_q;
  assign verdict_o.a_found = a_found_q;

  a_found_needs_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!found_q || a_found_q))
    else $error("B reported without A");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eval && s2_last_q) |=> (out_valid_q && phase_q == PH_SEEK_A && cnt_q == '0))
    else $error("verdict not issued or search not restarted");

endmodule

FILE: design/rolling_hash_two_pattern_sequence_match.sv
// ----------------------------------------------------------------------------
// rolling_hash_two_pattern_sequence_match
// Rolling-hash search for pattern A followed by a non-overlapping pattern B.
// ----------------------------------------------------------------------------
// Usage:
//   text_i carries one byte per transaction, with last on the final byte.
//   verdict_o carries one transaction per text, issued for the last byte:
//   a_found when A matched anywhere, found when B matched after A.
//   The config port writes pattern hashes, lengths and powers of 53
//   (index = register number); write only while no text is in flight.
// Throughput and verdict path:
//   One byte per cycle unless a held verdict stalls text_i. The verdict
//   passes the front, match and verdict registers. Each byte writes its
//   prefix hash to the history RAM and reads both window-start entries
//   via the two read ports in the same cycle, so the ports set the rate.
// Reset:
//   Registers take their defaults, text state clears; no RAM clearing pass,
//   slot zero of the ring reads as zero until overwritten in the text.
// Backpressure:
//   Bytes keep flowing while a verdict waits; text_i stalls only when a
//   second last byte reaches the verdict stage before the held one is taken.
// ----------------------------------------------------------------------------
module rolling_hash_two_pattern_sequence_match import rhsm_pkg::*; #(
  parameter int MAX_PAT = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rhsm_in_if.sink               text_i,
  rhsm_out_if.source            verdict_o
);

  localparam int RingDepth = MAX_PAT + 1;
  localparam int AddrW     = $clog2(RingDepth);

  cfg_t             cfg_q, cfg_d;
  s1_t              s1;
  logic             advance;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [31:0]      ram_wdata, ram_rdata_a, ram_rdata_b;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HASH_A: cfg_d.hash_a = cfg_data_i;
        REG_LEN_A:  cfg_d.len_a  = cfg_data_i[7:0];
        REG_POW_A:  cfg_d.pow_a  = cfg_data_i;
        REG_HASH_B: cfg_d.hash_b = cfg_data_i;
        REG_LEN_B:  cfg_d.len_b  = cfg_data_i[7:0];
        REG_POW_B:  cfg_d.pow_b  = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rhsm_front #(.MAX_PAT(MAX_PAT)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_i        (text_i),
    .cfg_i         (cfg_q),
    .advance_i     (advance),
    .s1_o          (s1),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_a_o (ram_raddr_a),
    .ram_raddr_b_o (ram_raddr_b)
  );

  rhsm_ram #(.Width(32), .Depth(RingDepth)) u_hist_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  rhsm_match #(.MAX_PAT(MAX_PAT)) u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .s1_i      (s1),
    .rdata_a_i (ram_rdata_a),
    .rdata_b_i (ram_rdata_b),
    .verdict_o (verdict_o),
    .advance_o (advance)
  );

endmodule
